### rtl/hex20_shape_function_eval_core_assert.svh
// assertion macros for the hex20 shape function core
// expects i_clk and i_rst_n in the scope of use
`ifndef HEX20_SHAPE_FUNCTION_EVAL_CORE_ASSERT_SVH
`define HEX20_SHAPE_FUNCTION_EVAL_CORE_ASSERT_SVH
// same-cycle implication
`define H20SF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define H20SF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/h20sf_pkg.sv
// types, codes and node table for the hex20 shape function core
// no dependencies
package h20sf_pkg;

    localparam int NODE_COUNT = 20;

    typedef struct packed {
        logic [1:0]         action;
        logic [4:0]         node;
        logic signed [15:0] r_coord;
        logic signed [15:0] s_coord;
        logic signed [15:0] t_coord;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] value;
        logic               bad_request;
    } t_out_beat;

    typedef enum logic [1:0] {ACT_VALUE, ACT_DR, ACT_DS, ACT_DT} t_action;

    // final right shift applied to the exact product
    typedef enum logic [1:0] {SH_25, SH_26, SH_38, SH_39} t_shift;

    localparam logic signed [1:0] SG_P = 2'sb01;
    localparam logic signed [1:0] SG_M = 2'sb11;
    localparam logic signed [1:0] SG_Z = 2'sb00;

    // index 0 is r, 1 is s, 2 is t
    typedef logic [2:0][1:0] t_node_pos;

    // four factors whose product is the unscaled result
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [17:0] b;
        logic signed [19:0] c;
        logic signed [19:0] d;
        t_shift             shift;
        logic               bad;
    } t_factors;

    function automatic t_node_pos node_pos(input logic [4:0] n);
        t_node_pos p;
        case (n)
            5'd0:    p = {SG_M, SG_M, SG_M};
            5'd1:    p = {SG_M, SG_M, SG_P};
            5'd2:    p = {SG_M, SG_P, SG_P};
            5'd3:    p = {SG_M, SG_P, SG_M};
            5'd4:    p = {SG_P, SG_M, SG_M};
            5'd5:    p = {SG_P, SG_M, SG_P};
            5'd6:    p = {SG_P, SG_P, SG_P};
            5'd7:    p = {SG_P, SG_P, SG_M};
            5'd8:    p = {SG_M, SG_M, SG_Z};
            5'd9:    p = {SG_M, SG_Z, SG_M};
            5'd10:   p = {SG_Z, SG_M, SG_M};
            5'd11:   p = {SG_M, SG_Z, SG_P};
            5'd12:   p = {SG_Z, SG_M, SG_P};
            5'd13:   p = {SG_M, SG_P, SG_Z};
            5'd14:   p = {SG_Z, SG_P, SG_P};
            5'd15:   p = {SG_Z, SG_P, SG_M};
            5'd16:   p = {SG_P, SG_M, SG_Z};
            5'd17:   p = {SG_P, SG_Z, SG_M};
            5'd18:   p = {SG_P, SG_Z, SG_P};
            5'd19:   p = {SG_P, SG_P, SG_Z};
            default: p = {SG_P, SG_P, SG_P};
        endcase
        return p;
    endfunction

endpackage

### rtl/h20sf_factor_sel.sv
// first stage logic: node decode, linear terms and factor selection
// depends on h20sf_pkg
module h20sf_factor_sel import h20sf_pkg::*; (
    input  t_in_beat i_beat,
    output t_factors o_fac
);

    t_node_pos          pos;
    logic signed [15:0] crd [3];
    logic signed [1:0]  sg  [3];
    logic signed [16:0] sc  [3];
    logic signed [17:0] l   [3];
    logic signed [18:0] sum;
    logic signed [19:0] dlin;
    logic signed [31:0] sq;
    logic signed [31:0] q;
    logic [1:0]         z, o1, o2, dx, oth;
    logic               mid;

    always_comb begin
        pos    = node_pos(i_beat.node);
        crd[0] = i_beat.r_coord;
        crd[1] = i_beat.s_coord;
        crd[2] = i_beat.t_coord;
        for (int i = 0; i < 3; i++) begin
            sg[i] = pos[i];
            case (pos[i])
                SG_P:    sc[i] = 17'(crd[i]);
                SG_M:    sc[i] = -17'(crd[i]);
                default: sc[i] = '0;
            endcase
            l[i] = 18'sd8192 + 18'(sc[i]);
        end
        sum = 19'(sc[0]) + 19'(sc[1]) + 19'(sc[2]);

        mid = 1'b1;
        if (sg[0] == SG_Z) z = 2'd0;
        else if (sg[1] == SG_Z) z = 2'd1;
        else if (sg[2] == SG_Z) z = 2'd2;
        else begin
            z   = 2'd0;
            mid = 1'b0;
        end

        dx = i_beat.action - 2'd1;
        if (dx == 2'd3) dx = 2'd0;

        // the two axes other than the one picked
        if (mid) begin
            case (z)
                2'd0:    begin o1 = 2'd1; o2 = 2'd2; end
                2'd1:    begin o1 = 2'd2; o2 = 2'd0; end
                default: begin o1 = 2'd0; o2 = 2'd1; end
            endcase
        end else begin
            case (dx)
                2'd0:    begin o1 = 2'd1; o2 = 2'd2; end
                2'd1:    begin o1 = 2'd2; o2 = 2'd0; end
                default: begin o1 = 2'd0; o2 = 2'd1; end
            endcase
        end
        oth = (dx == o1) ? o2 : o1;

        sq   = 32'(crd[z]) * 32'(crd[z]);
        q    = 32'sd67108864 - sq;
        dlin = 20'(sum) + 20'(sc[dx]) - 20'sd8192;
        if (sg[dx] == SG_M) dlin = -dlin;

        o_fac.bad = (i_beat.node >= 5'(NODE_COUNT));
        o_fac.d   = 20'sd1;
        if (!mid) begin
            if (i_beat.action == ACT_VALUE) begin
                o_fac.a     = 32'(l[0]);
                o_fac.b     = l[1];
                o_fac.c     = 20'(l[2]);
                o_fac.d     = 20'(sum) - 20'sd16384;
                o_fac.shift = SH_39;
            end else begin
                o_fac.a     = 32'(l[o1]);
                o_fac.b     = l[o2];
                o_fac.c     = dlin;
                o_fac.shift = SH_26;
            end
        end else begin
            if (i_beat.action == ACT_VALUE) begin
                o_fac.a     = q;
                o_fac.b     = l[o1];
                o_fac.c     = 20'(l[o2]);
                o_fac.shift = SH_38;
            end else if (dx == z) begin
                o_fac.a     = 32'(l[o1]);
                o_fac.b     = l[o2];
                o_fac.c     = -(20'(crd[z]) <<< 1);
                o_fac.shift = SH_25;
            end else begin
                o_fac.a     = q;
                o_fac.b     = l[oth];
                o_fac.c     = 20'(sg[dx]);
                o_fac.shift = SH_25;
            end
        end
    end

endmodule

### rtl/hex20_shape_function_eval_core.sv
// hex20 shape function core: input beats pass through the registered stages below to output beats;
// throughput one beat per cycle while i_ready is high; each stage holds only while the next one
// is full, so bubbles close up and a waiting result blocks new input only once all five stages are full.
// stages: factor select, two products, four partial products, sum, round and clamp.
// synchronous active-low reset clears the stage valid bits only.
module hex20_shape_function_eval_core import h20sf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    t_factors w_fac;

    logic [5:1] r_vld;
    logic [6:1] w_rdy;

    t_factors           r1_fac;
    logic signed [49:0] r2_x;
    logic signed [39:0] r2_y;
    t_shift             r2_sh, r3_sh, r4_sh;
    logic               r2_bad, r3_bad, r4_bad;
    logic [44:0]        r3_ll;
    logic signed [45:0] r3_lh, r3_hl;
    logic signed [44:0] r3_hh;
    logic signed [65:0] r4_p;
    t_out_beat          r5_out;

    logic signed [65:0] n4_p, w_half, w_shr;
    t_out_beat          n5_out;

    h20sf_factor_sel u_sel (
        .i_beat (i_data),
        .o_fac  (w_fac)
    );

    always_comb begin
        w_rdy[6] = i_ready;
        for (int k = 5; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[1];
    assign o_valid = r_vld[5];
    assign o_data  = r5_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) r_vld[1] <= i_valid;
            for (int k = 2; k <= 5; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        case (r3_sh)
            SH_25:   w_half = 66'sd1 <<< 24;
            SH_26:   w_half = 66'sd1 <<< 25;
            SH_38:   w_half = 66'sd1 <<< 37;
            default: w_half = 66'sd1 <<< 38;
        endcase
        n4_p = (66'(r3_hh) <<< 45) + (66'(r3_lh) <<< 20) + (66'(r3_hl) <<< 25)
             + 66'({21'd0, r3_ll}) + w_half;
    end

    always_comb begin
        case (r4_sh)
            SH_25:   w_shr = r4_p >>> 25;
            SH_26:   w_shr = r4_p >>> 26;
            SH_38:   w_shr = r4_p >>> 38;
            default: w_shr = r4_p >>> 39;
        endcase
        n5_out.bad_request = r4_bad;
        if (r4_bad) n5_out.value = '0;
        else if (w_shr > 66'sd2147483647) n5_out.value = 32'sh7fffffff;
        else if (w_shr < -66'sd2147483648) n5_out.value = 32'sh80000000;
        else n5_out.value = w_shr[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) r1_fac <= w_fac;
        if (w_rdy[2]) begin
            r2_x   <= 50'(r1_fac.a) * 50'(r1_fac.b);
            r2_y   <= 40'(r1_fac.c) * 40'(r1_fac.d);
            r2_sh  <= r1_fac.shift;
            r2_bad <= r1_fac.bad;
        end
        if (w_rdy[3]) begin
            // split both products so each multiplier stays narrow
            r3_ll  <= 45'(r2_x[24:0]) * 45'(r2_y[19:0]);
            r3_lh  <= 46'(signed'({1'b0, r2_x[24:0]})) * 46'(signed'(r2_y[39:20]));
            r3_hl  <= 46'(signed'(r2_x[49:25])) * 46'(signed'({1'b0, r2_y[19:0]}));
            r3_hh  <= 45'(signed'(r2_x[49:25])) * 45'(signed'(r2_y[39:20]));
            r3_sh  <= r2_sh;
            r3_bad <= r2_bad;
        end
        if (w_rdy[4]) begin
            r4_p   <= n4_p;
            r4_sh  <= r3_sh;
            r4_bad <= r3_bad;
        end
        if (w_rdy[5]) r5_out <= n5_out;
    end

`include "hex20_shape_function_eval_core_assert.svh"

    `H20SF_ASSERT_IMPL(a_bad_zero, o_valid && o_data.bad_request, o_data.value == 32'sd0, "bad beat")
    `H20SF_ASSERT_IMPL(a_full_when_busy, !o_ready, r_vld == 5'b11111, "stall with a bubble")
    `H20SF_ASSERT_NEXT(a_stage_hold, r_vld[3] && !w_rdy[4], r_vld[3] && $stable(r3_hh), "lost data")

endmodule

### test/tb_top.sv
// testbench for the hex20 shape function core: directed table, then random beats
// checked against an integer polynomial predictor; depends on h20sf_pkg and the core
module tb_top;
    import h20sf_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_beat o_data;

    hex20_shape_function_eval_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    t_out_beat shape_results[$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        errors_seen = 0;

    // sign of each node coordinate along r, s, t; 0 marks the quadratic axis
    function automatic int node_sign(input int n, input int ax);
        int tbl [20][3] = '{
            '{-1,-1,-1}, '{ 1,-1,-1}, '{ 1, 1,-1}, '{-1, 1,-1},
            '{-1,-1, 1}, '{ 1,-1, 1}, '{ 1, 1, 1}, '{-1, 1, 1},
            '{ 0,-1,-1}, '{-1, 0,-1}, '{-1,-1, 0}, '{ 1, 0,-1},
            '{ 1,-1, 0}, '{ 0, 1,-1}, '{ 1, 1, 0}, '{-1, 1, 0},
            '{ 0,-1, 1}, '{-1, 0, 1}, '{ 1, 0, 1}, '{ 0, 1, 1}};
        return tbl[n][ax];
    endfunction

    // round p / 2^k to nearest, ties up, then clamp
    function automatic logic signed [31:0] round_clamp(input longint p, input int k);
        longint q;
        q = (p + (longint'(1) <<< (k - 1))) >>> k;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic t_out_beat eval_shape(input t_in_beat b);
        t_out_beat r;
        longint c [3], sg [3], l [3];
        longint sum, p, q;
        int z, d, o1, o2, other, n;
        r.value = '0;
        r.bad_request = 1'b0;
        n = int'(b.node);
        if (n >= NODE_COUNT) begin
            r.bad_request = 1'b1;
            return r;
        end
        c[0] = longint'(b.r_coord); c[1] = longint'(b.s_coord); c[2] = longint'(b.t_coord);
        z = -1;
        for (int i = 0; i < 3; i++) begin
            sg[i] = longint'(node_sign(n, i));
            l[i] = 8192 + sg[i] * c[i];
            if (sg[i] == 0) z = i;
        end
        d = int'(b.action) - 1;
        if (z < 0) begin
            sum = sg[0]*c[0] + sg[1]*c[1] + sg[2]*c[2];
            if (t_action'(b.action) == ACT_VALUE) begin
                r.value = round_clamp(l[0]*l[1]*l[2]*(sum - 16384), 39);
            end else begin
                o1 = (d + 1) % 3; o2 = (d + 2) % 3;
                p = sg[d] * (l[o1]*l[o2]*(sum + sg[d]*c[d] - 8192));
                r.value = round_clamp(p, 26);
            end
        end else begin
            o1 = (z + 1) % 3; o2 = (z + 2) % 3;
            q = (longint'(1) <<< 26) - c[z]*c[z];
            if (t_action'(b.action) == ACT_VALUE) begin
                r.value = round_clamp(q*l[o1]*l[o2], 38);
            end else begin
                if (d == z) p = -2*c[z]*l[o1]*l[o2];
                else begin
                    other = (d == o1) ? o2 : o1;
                    p = sg[d]*q*l[other];
                end
                r.value = round_clamp(p, 25);
            end
        end
        return r;
    endfunction

    function automatic t_in_beat mk(input t_action a, input int n,
                                    input int r, input int s, input int t);
        t_in_beat b;
        b.action = a; b.node = n[4:0];
        b.r_coord = r[15:0]; b.s_coord = s[15:0]; b.t_coord = t[15:0];
        return b;
    endfunction

    // known results: origin values of a corner and an edge node, bad nodes
    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat known;
    } t_dir_row;

    t_dir_row dir_rows [$];

    // valid stays high between back-to-back beats and drops only while idling
    task automatic send_beat(input t_in_beat b);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        shape_results.push_back(eval_shape(b));
        @(negedge i_clk);
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (shape_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %p", o_data);
            end else begin
                exp_beat = shape_results.pop_front();
                if (o_data.value !== exp_beat.value
                        || o_data.bad_request !== exp_beat.bad_request) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value %0d bad %b, got value %0d bad %b",
                                 exp_beat.value, exp_beat.bad_request,
                                 o_data.value, o_data.bad_request);
                end
            end
        end
        if (cycle_count > 400000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int rand_coord();
        case ($urandom_range(4, 0))
            0: return $urandom_range(1, 0) ? 32767 : -32768;
            1: return $urandom_range(1, 0) ? 8192 : -8192;
            2: return int'($urandom_range(16384, 0)) - 8192;
            default: return int'($urandom_range(65535, 0)) - 32768;
        endcase
    endfunction

    initial begin
        t_dir_row row;
        t_in_beat b;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // node 0 at origin: -2/8 = -0.25; edge node 8 at origin: 1/4
        row = '{mk(ACT_VALUE, 0, 0, 0, 0), 1'b1, '{-32'sd16384, 1'b0}};
        dir_rows.push_back(row);
        row = '{mk(ACT_VALUE, 8, 0, 0, 0), 1'b1, '{32'sd16384, 1'b0}};
        dir_rows.push_back(row);
        row = '{mk(ACT_DT, 31, 32767, -32768, 5), 1'b1, '{32'sd0, 1'b1}};
        dir_rows.push_back(row);
        row = '{mk(ACT_VALUE, 20, 0, 0, 0), 1'b1, '{32'sd0, 1'b1}};
        dir_rows.push_back(row);
        for (int a = 0; a < 4; a++) begin
            row = '{mk(t_action'(a), 6, 32767, 32767, 32767), 1'b0, '{0, 0}};
            dir_rows.push_back(row);
            row = '{mk(t_action'(a), 0, -32768, -32768, -32768), 1'b0, '{0, 0}};
            dir_rows.push_back(row);
            row = '{mk(t_action'(a), 10, -32768, 32767, -32768), 1'b0, '{0, 0}};
            dir_rows.push_back(row);
            row = '{mk(t_action'(a), 19, 8192, -8192, 32767), 1'b0, '{0, 0}};
            dir_rows.push_back(row);
            row = '{mk(t_action'(a), 13, 32767, 32767, -32768), 1'b0, '{0, 0}};
            dir_rows.push_back(row);
        end
        foreach (dir_rows[k]) begin
            send_beat(dir_rows[k].beat);
            if (dir_rows[k].typed) begin
                shape_results.pop_back();
                shape_results.push_back(dir_rows[k].known);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 24 : 0;
            repeat (410) begin
                b.action  = 2'($urandom_range(3, 0));
                b.node    = ($urandom_range(9, 0) == 0) ? 5'($urandom_range(31, 20))
                                                        : 5'($urandom_range(19, 0));
                b.r_coord = 16'(rand_coord());
                b.s_coord = 16'(rand_coord());
                b.t_coord = 16'(rand_coord());
                send_beat(b);
            end
        end
        i_valid <= 1'b0;

        while (shape_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("checked %0d result beats over all 20 nodes, four actions and bad nodes",
                 results_seen);
        $display("idle mixes: sender-light/receiver-heavy, reversed, and full rate");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
